// ===== rtl/bcmp_pkg.sv =====
package bcmp_pkg;

    localparam int TABLE_SIZE = 4096;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int RES_W      = 30;
    localparam int TAG_W      = 32;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [RES_W-1:0] PRIME      = 30'd1000000007;
    localparam logic [RES_W-1:0] FERMAT_EXP = PRIME - 30'd2;

    // Barrett constant floor(2^60 / p); it fits in 31 bits.
    localparam logic [63:0] MU_FULL = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0] MU      = MU_FULL[30:0];

    typedef struct packed {
        logic signed [31:0] n_value;
        logic signed [31:0] r_value;
    } query_t;

    typedef struct packed {
        logic [RES_W-1:0] coefficient;
        logic             out_of_range;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [RES_W-1:0] a;
        logic [RES_W-1:0] b;
        logic [TAG_W-1:0] tag;
    } mul_req_t;

    typedef struct packed {
        logic             valid;
        logic [RES_W-1:0] res;
        logic [TAG_W-1:0] tag;
    } mul_rsp_t;

    typedef struct packed {
        logic             fact_we;
        logic             inv_we;
        logic [IDX_W-1:0] addr;
        logic [RES_W-1:0] data;
    } tbl_wr_t;

endpackage

// ===== rtl/binomial_coefficient_mod_prime.sv =====
// Channel  | Signals                             | Payload
// ---------+-------------------------------------+----------------------------------
// query    | query_valid, query_stall, query     | n_value, r_value (signed 32 bit)
// result   | result_valid, result_stall, result  | coefficient (30 bit), out_of_range
//
// After reset the block builds its tables and holds query_stall high meanwhile: the
// factorials and their inverses are computed on the five-stage modular multiplier, and
// the sequencer waits for each product before it issues the next request.
// Once built, one query transaction is taken per cycle while the output queue has room;
// its result passes a table read, two chained modular multiplies and an output queue write.
// A stalled result side fills the 16-entry output queue; query_stall rises when every
// queue slot is claimed by an item in flight or waiting.
module binomial_coefficient_mod_prime (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                query_valid,
    output logic                query_stall,
    input  bcmp_pkg::query_t    query,
    output logic                result_valid,
    input  logic                result_stall,
    output bcmp_pkg::result_t   result
);

    localparam logic [bcmp_pkg::FIFO_AW:0] DEPTH = (bcmp_pkg::FIFO_AW + 1)'(bcmp_pkg::FIFO_DEPTH);
    localparam logic [bcmp_pkg::FIFO_AW:0] PTR_ONE = (bcmp_pkg::FIFO_AW + 1)'(1);

    logic                        tables_ready;
    bcmp_pkg::mul_req_t          build_req, req_a, req_b;
    bcmp_pkg::mul_rsp_t          rsp_a, rsp_b;
    bcmp_pkg::tbl_wr_t           tbl_wr;

    logic [bcmp_pkg::RES_W-1:0]  fact_q, inv_r_q, inv_d_q;
    logic [31:0]                 diff;
    logic                        accept, deliver;
    logic                        flag, zero;

    logic                        rd_valid_reg;
    logic                        rd_flag_reg, rd_zero_reg;

    logic [bcmp_pkg::FIFO_AW:0]  cnt_reg, cnt_next;
    logic [bcmp_pkg::FIFO_AW:0]  wr_ptr_reg, rd_ptr_reg;
    bcmp_pkg::result_t           fifo_mem [bcmp_pkg::FIFO_DEPTH];
    bcmp_pkg::result_t           fifo_in;

    assign accept  = query_valid && !query_stall;
    assign deliver = result_valid && !result_stall;

    // Decode the special cases at acceptance; they ride along as tag bits.
    assign diff = query.n_value - query.r_value;
    assign flag = !query.n_value[31] &&
                  (query.n_value[30:0] >= 31'(bcmp_pkg::TABLE_SIZE));
    assign zero = flag || query.n_value[31] || query.r_value[31] ||
                  ($signed(query.r_value) > $signed(query.n_value));

    bcmp_builder u_builder (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (build_req),
        .rsp   (rsp_a),
        .wr    (tbl_wr),
        .ready (tables_ready)
    );

    bcmp_tables u_tables (
        .clk     (clk),
        .wr      (tbl_wr),
        .n_addr  (query.n_value[bcmp_pkg::IDX_W-1:0]),
        .r_addr  (query.r_value[bcmp_pkg::IDX_W-1:0]),
        .d_addr  (diff[bcmp_pkg::IDX_W-1:0]),
        .fact_q  (fact_q),
        .inv_r_q (inv_r_q),
        .inv_d_q (inv_d_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_flag_reg <= flag;
        rd_zero_reg <= zero;
    end

    // The first multiplier serves the table build until it is done, then the queries.
    // The inverse factorial of n - r travels in the tag to meet the first product.
    always_comb
    begin
        if (tables_ready)
        begin
            req_a.start = rd_valid_reg;
            req_a.a     = fact_q;
            req_a.b     = inv_r_q;
            req_a.tag   = {inv_d_q, rd_zero_reg, rd_flag_reg};
        end
        else
        begin
            req_a = build_req;
        end
    end

    bcmp_modmul u_mul_a (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_a),
        .rsp   (rsp_a)
    );

    assign req_b.start = rsp_a.valid && tables_ready;
    assign req_b.a     = rsp_a.res;
    assign req_b.b     = rsp_a.tag[bcmp_pkg::TAG_W-1:2];
    assign req_b.tag   = {30'd0, rsp_a.tag[1:0]};

    bcmp_modmul u_mul_b (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_b),
        .rsp   (rsp_b)
    );

    assign fifo_in.coefficient  = rsp_b.tag[1] ? '0 : rsp_b.res;
    assign fifo_in.out_of_range = rsp_b.tag[0];

    // Every accepted transaction owns a queue slot, so the pipeline never backs up.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && !deliver)
        begin
            cnt_next = cnt_reg + PTR_ONE;
        end
        else if (!accept && deliver)
        begin
            cnt_next = cnt_reg - PTR_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (rsp_b.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_ONE;
            end
            if (deliver)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_ONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_b.valid)
        begin
            fifo_mem[wr_ptr_reg[bcmp_pkg::FIFO_AW-1:0]] <= fifo_in;
        end
    end

    assign query_stall  = !tables_ready || (cnt_reg == DEPTH);
    assign result_valid = (wr_ptr_reg != rd_ptr_reg);
    assign result       = fifo_mem[rd_ptr_reg[bcmp_pkg::FIFO_AW-1:0]];

endmodule

// ===== rtl/bcmp_modmul.sv =====
// Five-stage modular multiplier: product, then Barrett reduction.
module bcmp_modmul (
    input  logic                clk,
    input  logic                rst_n,
    input  bcmp_pkg::mul_req_t  req,
    output bcmp_pkg::mul_rsp_t  rsp
);

    logic [4:0]                   valid_reg;
    logic [bcmp_pkg::TAG_W-1:0]   tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    logic [59:0]                  prod1_reg;
    logic [61:0]                  q2_reg;
    logic [31:0]                  x2_reg, x3_reg;
    logic [60:0]                  qp3_reg;
    logic [31:0]                  r4_reg;
    logic [bcmp_pkg::RES_W-1:0]   res5_reg;

    logic [59:0]                  prod;
    logic [31:0]                  two_p;
    logic [bcmp_pkg::RES_W-1:0]   res_next;

    assign prod  = 60'(req.a) * 60'(req.b);
    assign two_p = {1'b0, bcmp_pkg::PRIME, 1'b0};

    // The Barrett remainder is below three times the prime.
    always_comb
    begin
        if (r4_reg >= two_p)
        begin
            res_next = 30'(r4_reg - two_p);
        end
        else if (r4_reg >= 32'(bcmp_pkg::PRIME))
        begin
            res_next = 30'(r4_reg - 32'(bcmp_pkg::PRIME));
        end
        else
        begin
            res_next = r4_reg[29:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], req.start};
        end
    end

    always_ff @(posedge clk)
    begin
        prod1_reg <= prod;
        tag1_reg  <= req.tag;
        q2_reg    <= 62'(prod1_reg[59:29]) * 62'(bcmp_pkg::MU);
        x2_reg    <= prod1_reg[31:0];
        tag2_reg  <= tag1_reg;
        qp3_reg   <= 61'(q2_reg[61:31]) * 61'(bcmp_pkg::PRIME);
        x3_reg    <= x2_reg;
        tag3_reg  <= tag2_reg;
        r4_reg    <= x3_reg - qp3_reg[31:0];
        tag4_reg  <= tag3_reg;
        res5_reg  <= res_next;
        tag5_reg  <= tag4_reg;
    end

    assign rsp.valid = valid_reg[4];
    assign rsp.res   = res5_reg;
    assign rsp.tag   = tag5_reg;

endmodule

// ===== rtl/bcmp_tables.sv =====
// Factorial and inverse factorial memories, one write port, registered reads.
module bcmp_tables (
    input  logic                              clk,
    input  bcmp_pkg::tbl_wr_t                 wr,
    input  logic [bcmp_pkg::IDX_W-1:0]        n_addr,
    input  logic [bcmp_pkg::IDX_W-1:0]        r_addr,
    input  logic [bcmp_pkg::IDX_W-1:0]        d_addr,
    output logic [bcmp_pkg::RES_W-1:0]        fact_q,
    output logic [bcmp_pkg::RES_W-1:0]        inv_r_q,
    output logic [bcmp_pkg::RES_W-1:0]        inv_d_q
);

    logic [bcmp_pkg::RES_W-1:0] fact_mem [bcmp_pkg::TABLE_SIZE];
    logic [bcmp_pkg::RES_W-1:0] inv_mem  [bcmp_pkg::TABLE_SIZE];

    always_ff @(posedge clk)
    begin
        if (wr.fact_we)
        begin
            fact_mem[wr.addr] <= wr.data;
        end
        if (wr.inv_we)
        begin
            inv_mem[wr.addr] <= wr.data;
        end
        fact_q  <= fact_mem[n_addr];
        inv_r_q <= inv_mem[r_addr];
        inv_d_q <= inv_mem[d_addr];
    end

endmodule

// ===== rtl/bcmp_builder.sv =====
// Sequencer that fills both tables after reset through the shared multiplier.
module bcmp_builder (
    input  logic                clk,
    input  logic                rst_n,
    output bcmp_pkg::mul_req_t  req,
    input  bcmp_pkg::mul_rsp_t  rsp,
    output bcmp_pkg::tbl_wr_t   wr,
    output logic                ready
);

    typedef enum logic [5:0] {
        S_INIT = 6'b000001,
        S_FACT = 6'b000010,
        S_PACC = 6'b000100,
        S_PSQ  = 6'b001000,
        S_INV  = 6'b010000,
        S_DONE = 6'b100000
    } build_state_t;

    localparam logic [bcmp_pkg::IDX_W-1:0] LAST = bcmp_pkg::IDX_W'(bcmp_pkg::TABLE_SIZE - 1);
    localparam logic [bcmp_pkg::IDX_W-1:0] ONE  = bcmp_pkg::IDX_W'(1);

    build_state_t                 state_reg, state_next;
    logic                         pend_reg, pend_next;
    logic [bcmp_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [bcmp_pkg::RES_W-1:0]   prev_reg, prev_next;
    logic [bcmp_pkg::RES_W-1:0]   acc_reg, acc_next;
    logic [bcmp_pkg::RES_W-1:0]   sq_reg, sq_next;
    logic [bcmp_pkg::RES_W-1:0]   exp_reg, exp_next;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        exp_next   = exp_reg;
        req        = '0;
        wr         = '0;
        case (state_reg)
            S_INIT:
            begin
                wr.fact_we = 1'b1;
                wr.addr    = '0;
                wr.data    = 30'd1;
                idx_next   = ONE;
                prev_next  = 30'd1;
                state_next = S_FACT;
            end
            S_FACT:
            begin
                if (!pend_reg)
                begin
                    req.start = 1'b1;
                    req.a     = bcmp_pkg::RES_W'(idx_reg);
                    req.b     = prev_reg;
                    pend_next = 1'b1;
                end
                else if (rsp.valid)
                begin
                    pend_next  = 1'b0;
                    wr.fact_we = 1'b1;
                    wr.addr    = idx_reg;
                    wr.data    = rsp.res;
                    prev_next  = rsp.res;
                    if (idx_reg == LAST)
                    begin
                        acc_next   = 30'd1;
                        sq_next    = rsp.res;
                        exp_next   = bcmp_pkg::FERMAT_EXP;
                        state_next = S_PACC;
                    end
                    else
                    begin
                        idx_next = idx_reg + ONE;
                    end
                end
            end
            S_PACC:
            begin
                if (exp_reg == '0)
                begin
                    wr.inv_we  = 1'b1;
                    wr.addr    = LAST;
                    wr.data    = acc_reg;
                    prev_next  = acc_reg;
                    idx_next   = LAST;
                    state_next = S_INV;
                end
                else if (!exp_reg[0])
                begin
                    state_next = S_PSQ;
                end
                else if (!pend_reg)
                begin
                    req.start = 1'b1;
                    req.a     = acc_reg;
                    req.b     = sq_reg;
                    pend_next = 1'b1;
                end
                else if (rsp.valid)
                begin
                    pend_next  = 1'b0;
                    acc_next   = rsp.res;
                    state_next = S_PSQ;
                end
            end
            S_PSQ:
            begin
                if (!pend_reg)
                begin
                    req.start = 1'b1;
                    req.a     = sq_reg;
                    req.b     = sq_reg;
                    pend_next = 1'b1;
                end
                else if (rsp.valid)
                begin
                    pend_next  = 1'b0;
                    sq_next    = rsp.res;
                    exp_next   = exp_reg >> 1;
                    state_next = S_PACC;
                end
            end
            S_INV:
            begin
                if (!pend_reg)
                begin
                    req.start = 1'b1;
                    req.a     = prev_reg;
                    req.b     = bcmp_pkg::RES_W'(idx_reg);
                    pend_next = 1'b1;
                end
                else if (rsp.valid)
                begin
                    pend_next = 1'b0;
                    wr.inv_we = 1'b1;
                    wr.addr   = idx_reg - ONE;
                    wr.data   = rsp.res;
                    prev_next = rsp.res;
                    if (idx_reg == ONE)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg - ONE;
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_DONE;
            end
            default:
            begin
                state_next = S_INIT;
                pend_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            pend_reg  <= 1'b0;
            idx_reg   <= '0;
            prev_reg  <= '0;
            acc_reg   <= '0;
            sq_reg    <= '0;
            exp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
            prev_reg  <= prev_next;
            acc_reg   <= acc_next;
            sq_reg    <= sq_next;
            exp_reg   <= exp_next;
        end
    end

    assign ready = (state_reg == S_DONE);

endmodule

// ===== rtl/bcmp_checker.sv =====
module bcmp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               query_valid,
    input logic               query_stall,
    input bcmp_pkg::query_t   query,
    input logic               result_valid,
    input logic               result_stall,
    input bcmp_pkg::result_t  result
);

    // A waiting result holds until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // A flagged index never carries a coefficient.
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_of_range |-> result.coefficient == '0)
        else $error("out of range result with nonzero coefficient");

    // Coefficients are fully reduced.
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.coefficient < bcmp_pkg::PRIME)
        else $error("coefficient not reduced");

    // The tables are never ready right after reset.
    a_build_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> query_stall && !result_valid)
        else $error("queries taken before the tables were built");

endmodule

bind binomial_coefficient_mod_prime bcmp_checker u_bcmp_checker (.*);

// ===== tb/tb_binomial_coefficient_mod_prime.sv =====
`timescale 1ns / 1ps

// Scoreboard: holds its own factorial and inverse factorial tables and the queue
// of coefficients that are still due from the block.
class coef_scoreboard;
    localparam longint unsigned P = 64'd1000000007;

    longint unsigned   fact_tbl [bcmp_pkg::TABLE_SIZE];
    longint unsigned   inv_tbl  [bcmp_pkg::TABLE_SIZE];
    bcmp_pkg::result_t due_q [$];
    int                mismatches;
    int                unexpected;
    int                checked;

    function new();
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned e;
        fact_tbl[0] = 1;
        for (int i = 1; i < bcmp_pkg::TABLE_SIZE; i++)
            fact_tbl[i] = (fact_tbl[i-1] * i) % P;
        // Fermat inverse of the top factorial by square and multiply.
        acc = 1;
        sq  = fact_tbl[bcmp_pkg::TABLE_SIZE-1];
        e   = P - 2;
        while (e != 0)
        begin
            if (e[0])
                acc = (acc * sq) % P;
            sq = (sq * sq) % P;
            e  = e >> 1;
        end
        inv_tbl[bcmp_pkg::TABLE_SIZE-1] = acc;
        for (int i = bcmp_pkg::TABLE_SIZE - 1; i > 0; i--)
            inv_tbl[i-1] = (inv_tbl[i] * i) % P;
        mismatches = 0;
        unexpected = 0;
        checked    = 0;
    endfunction

    function void note_query(bcmp_pkg::query_t q);
        bcmp_pkg::result_t exp_r;
        longint            n;
        longint            r;
        longint unsigned   c;
        n = q.n_value;
        r = q.r_value;
        exp_r = '0;
        if (n >= bcmp_pkg::TABLE_SIZE)
            exp_r.out_of_range = 1'b1;
        else if (n >= 0 && r >= 0 && r <= n)
        begin
            c = (fact_tbl[n] * inv_tbl[r]) % P;
            c = (c * inv_tbl[n-r]) % P;
            exp_r.coefficient = c[bcmp_pkg::RES_W-1:0];
        end
        due_q.push_back(exp_r);
    endfunction

    function void check_result(bcmp_pkg::result_t got);
        bcmp_pkg::result_t exp_r;
        if (due_q.size() == 0)
        begin
            unexpected++;
            if (mismatches + unexpected <= 10)
                $display("ERROR: result transaction with nothing due: coef=%0d oor=%0b",
                         got.coefficient, got.out_of_range);
            return;
        end
        exp_r = due_q.pop_front();
        checked++;
        if (got.coefficient !== exp_r.coefficient || got.out_of_range !== exp_r.out_of_range)
        begin
            mismatches++;
            if (mismatches + unexpected <= 10)
                $display("ERROR: result %0d: expected coef=%0d oor=%0b, got coef=%0d oor=%0b",
                         checked, exp_r.coefficient, exp_r.out_of_range,
                         got.coefficient, got.out_of_range);
        end
    endfunction

    function int pending();
        return due_q.size();
    endfunction
endclass

module tb_binomial_coefficient_mod_prime;

    logic              clk;
    logic              rst_n;
    logic              query_valid;
    logic              query_stall;
    bcmp_pkg::query_t  query;
    logic              result_valid;
    logic              result_stall;
    bcmp_pkg::result_t result;

    coef_scoreboard sb;

    // Control between the sender and the receiver processes.
    bit      rx_no_idle;
    bit      tx_no_idle;
    bit      long_hold_req;
    int      sent;

    binomial_coefficient_mod_prime u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .query        (query),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Offer one query transaction after a random gap and wait until it is taken.
    // Valid is only lowered when a gap is actually inserted, so back-to-back
    // transactions keep it high.
    task automatic send_query(input bcmp_pkg::query_t q);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            query_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        query_valid <= 1'b1;
        query       <= q;
        @(posedge clk);
        while (query_stall)
            @(posedge clk);
        sb.note_query(q);
        sent++;
    endtask

    task automatic send_pair(input int n, input int r);
        bcmp_pkg::query_t q;
        q.n_value = n;
        q.r_value = r;
        send_query(q);
    endtask

    // Random queries: mostly well formed indexes inside the table, with a share
    // of r greater than n, negative indexes, n beyond the table and raw 32-bit noise.
    task automatic send_random();
        bcmp_pkg::query_t q;
        int               kind;
        int               n;
        kind = $urandom_range(0, 99);
        if (kind < 65)
        begin
            // Small n most of the time, the whole table now and then.
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, bcmp_pkg::TABLE_SIZE - 1)
                                            : $urandom_range(0, 64);
            q.n_value = n;
            q.r_value = $urandom_range(0, n);
        end
        else if (kind < 75)
        begin
            n = $urandom_range(0, bcmp_pkg::TABLE_SIZE - 2);
            q.n_value = n;
            q.r_value = $urandom_range(n + 1, bcmp_pkg::TABLE_SIZE + 10);
        end
        else if (kind < 85)
        begin
            q.n_value = $urandom_range(0, 1) ? -$signed($urandom_range(1, 5000))
                                             : $urandom_range(0, bcmp_pkg::TABLE_SIZE - 1);
            q.r_value = -$signed($urandom_range(1, 5000));
        end
        else if (kind < 90)
        begin
            q.n_value = $urandom_range(bcmp_pkg::TABLE_SIZE, bcmp_pkg::TABLE_SIZE + 100);
            q.r_value = $urandom;
        end
        else
        begin
            q.n_value = $urandom;
            q.r_value = $urandom;
        end
        send_query(q);
    endtask

    // Receiver: random stall before each result transaction, plus one long
    // hold-off on request so that the output queue fills and the input stalls.
    initial
    begin
        int k;
        result_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                result_stall <= 1'b1;
                repeat (300) @(posedge clk);
                long_hold_req = 1'b0;
            end
            k = rx_no_idle ? 0 : $urandom_range(0, 19);
            if (k > 0)
            begin
                result_stall <= 1'b1;
                repeat (k) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid && !long_hold_req)
                @(posedge clk);
        end
    end

    // Every accepted result transaction goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    initial
    begin
        #20ms;
        $display("tb_binomial_coefficient_mod_prime failed");
        $finish;
    end

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        query_valid   = 1'b0;
        query         = '0;
        rx_no_idle    = 1'b0;
        tx_no_idle    = 1'b0;
        long_hold_req = 1'b0;
        sent          = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: table edges, out of range n, negative indexes, r above n.
        // The first query waits out the table build behind query_stall.
        send_pair(0, 0);
        send_pair(1, 0);
        send_pair(1, 1);
        send_pair(10, 3);
        send_pair(bcmp_pkg::TABLE_SIZE - 1, 0);
        send_pair(bcmp_pkg::TABLE_SIZE - 1, bcmp_pkg::TABLE_SIZE - 1);
        send_pair(bcmp_pkg::TABLE_SIZE - 1, bcmp_pkg::TABLE_SIZE / 2);
        send_pair(bcmp_pkg::TABLE_SIZE - 1, 1);
        send_pair(3000, 1500);
        send_pair(bcmp_pkg::TABLE_SIZE, 0);
        send_pair(bcmp_pkg::TABLE_SIZE, -1);
        send_pair(32'h7fffffff, 32'h7fffffff);
        send_pair(32'h80000000, 32'h80000000);
        send_pair(32'h7fffffff, 0);
        send_pair(-1, 0);
        send_pair(0, -1);
        send_pair(-5, -7);
        send_pair(100, -5);
        send_pair(5, 6);
        send_pair(bcmp_pkg::TABLE_SIZE - 2, bcmp_pkg::TABLE_SIZE - 1);
        send_pair(0, 32'h7fffffff);
        send_pair(-1, -1);

        for (int i = 0; i < 1600; i++)
        begin
            if (i == 400)
            begin
                // Receiver holds off while the sender streams without gaps.
                long_hold_req = 1'b1;
                tx_no_idle    = 1'b1;
            end
            if (i == 500)
                tx_no_idle = 1'b0;
            if (i == 800)
            begin
                // Let the block drain completely before going on.
                query_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            if (i == 1000)
            begin
                tx_no_idle = 1'b1;
                rx_no_idle = 1'b1;
            end
            if (i == 1150)
            begin
                tx_no_idle = 1'b0;
                rx_no_idle = 1'b0;
            end
            send_random();
        end
        query_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Run covered %0d queries: table edges, out of range and negative indexes,",
                 sent);
        $display("r above n, random indexes, a long receiver hold-off and a full drain.");
        if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending() == 0)
            $display("tb_binomial_coefficient_mod_prime passed");
        else
            $display("tb_binomial_coefficient_mod_prime failed");
        $finish;
    end

endmodule
